### rtl/rtc_three_wire_bcd_master_macros.svh
// Assertion macros for the three-wire real-time-clock serial master.
// Used by the checker; depends on nothing else.
`ifndef RTC_THREE_WIRE_BCD_MASTER_MACROS_SVH
`define RTC_THREE_WIRE_BCD_MASTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTC3W_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtc3w check failed");

// The signal must keep its value in the cycle after the condition.
`define RTC3W_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("rtc3w hold check failed");

`endif

### rtl/rtc3w_pkg.sv
// Shared types, constants and helper functions for the three-wire RTC master.
// Used by the sequencer and the top level; depends on nothing else.
`default_nettype none

package rtc3w_pkg;

    localparam int ENABLE_WAIT_TICKS = 4;
    localparam int BIT_WAIT_TICKS    = 1;

    localparam logic [7:0] EN_WAIT  = 8'(ENABLE_WAIT_TICKS - 1);
    localparam logic [7:0] BIT_WAIT = 8'(BIT_WAIT_TICKS - 1);

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [2:0] FIELD_SEC   = 3'd0;
    localparam logic [2:0] FIELD_MIN   = 3'd1;
    localparam logic [2:0] FIELD_HOUR  = 3'd2;
    localparam logic [2:0] FIELD_DATE  = 3'd3;
    localparam logic [2:0] FIELD_MONTH = 3'd4;
    localparam logic [2:0] FIELD_YEAR  = 3'd5;

    localparam logic [4:0] READ_BITS  = 5'd8;
    localparam logic [4:0] WRITE_BITS = 5'd16;
    localparam logic [6:0] VALUE_MAX  = 7'd99;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_ENWAIT = 8'b0000_0010,
        PH_SETUP  = 8'b0000_0100,
        PH_HIGH   = 8'b0000_1000,
        PH_LOW    = 8'b0001_0000,
        PH_TURN   = 8'b0010_0000,
        PH_RHIGH  = 8'b0100_0000,
        PH_RLOW   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       busy;
        logic       done;
        logic [6:0] read_value;
        logic       start_rejected;
    } result_t;

    function automatic logic [2:0] sat_field(input logic [2:0] fidx);
        sat_field = (fidx > FIELD_YEAR) ? FIELD_YEAR : fidx;
    endfunction

    function automatic logic [7:0] read_cmd(input logic [2:0] fidx);
        case (fidx)
            FIELD_SEC:   read_cmd = 8'h81;
            FIELD_MIN:   read_cmd = 8'h83;
            FIELD_HOUR:  read_cmd = 8'h85;
            FIELD_DATE:  read_cmd = 8'h87;
            FIELD_MONTH: read_cmd = 8'h89;
            default:     read_cmd = 8'h8d;
        endcase
    endfunction

    function automatic logic [3:0] tens_mask(input logic [2:0] fidx);
        case (fidx)
            FIELD_SEC:   tens_mask = 4'h7;
            FIELD_MIN:   tens_mask = 4'hf;
            FIELD_HOUR:  tens_mask = 4'h3;
            FIELD_DATE:  tens_mask = 4'h3;
            FIELD_MONTH: tens_mask = 4'h1;
            default:     tens_mask = 4'hf;
        endcase
    endfunction

    // Binary to BCD; the tens digit comes from a multiply by 205/2048,
    // which is exact for every 7-bit value.
    function automatic logic [7:0] bcd_encode(input logic [6:0] w);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  q10;
        logic [6:0]  rem;
        prod = 15'(w) * 15'd205;
        q    = prod[14:11];
        q10  = 7'({q, 3'b000}) + 7'({q, 1'b0});
        rem  = w - q10;
        bcd_encode = {q, rem[3:0]};
    endfunction

    // BCD to binary with the field's tens mask; saturates at 99.
    function automatic logic [6:0] bcd_decode(input logic [7:0] b, input logic [2:0] fidx);
        logic [3:0] t;
        logic [7:0] v;
        t = b[7:4] & tens_mask(fidx);
        v = 8'({t, 3'b000}) + 8'({t, 1'b0}) + 8'(b[3:0]);
        bcd_decode = (v > 8'(VALUE_MAX)) ? VALUE_MAX : v[6:0];
    endfunction

endpackage

`default_nettype wire

### rtl/rtc3w_seq.sv
// Transaction sequencer: phase, counters, shift word and pin levels for one tick.
// Depends on rtc3w_pkg.
`default_nettype none

module rtc3w_seq
    import rtc3w_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [1:0] func,
    input  wire logic [2:0] field_index,
    input  wire logic [6:0] write_value,
    input  wire logic       io_in,
    output result_t         result
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [7:0]  wait_count_reg, wait_count_next;
    logic [15:0] shift_word_reg, shift_word_next;
    logic [7:0]  read_byte_reg, read_byte_next;
    logic [2:0]  active_field_reg, active_field_next;
    logic        writing_reg, writing_next;
    logic        ce_reg, ce_next;
    logic        sclk_reg, sclk_next;
    logic        io_reg, io_next;
    logic        drive_reg, drive_next;

    logic        start;
    logic [2:0]  fidx;
    logic [7:0]  cmd;
    logic [4:0]  bit_inc;
    logic [4:0]  bit_limit;
    logic        done;
    logic        rejected;
    logic [6:0]  rval;

    assign start     = (func == FUNC_READ) || (func == FUNC_WRITE);
    assign fidx      = sat_field(field_index);
    assign cmd       = read_cmd(fidx);
    assign bit_inc   = bit_count_reg + 5'd1;
    assign bit_limit = writing_reg ? WRITE_BITS : READ_BITS;

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        wait_count_next   = wait_count_reg;
        shift_word_next   = shift_word_reg;
        read_byte_next    = read_byte_reg;
        active_field_next = active_field_reg;
        writing_next      = writing_reg;
        ce_next           = ce_reg;
        sclk_next         = sclk_reg;
        io_next           = io_reg;
        drive_next        = drive_reg;
        done              = 1'b0;
        rejected          = 1'b0;
        rval              = '0;

        if (phase_reg == PH_IDLE) begin
            if (start) begin
                active_field_next = fidx;
                writing_next      = (func == FUNC_WRITE);
                if (func == FUNC_WRITE) begin
                    shift_word_next = {bcd_encode(write_value), cmd & 8'hfe};
                end else begin
                    shift_word_next = {8'h00, cmd};
                end
                read_byte_next  = '0;
                bit_count_next  = '0;
                ce_next         = 1'b1;
                drive_next      = 1'b1;
                phase_next      = PH_ENWAIT;
                wait_count_next = EN_WAIT;
            end
        end else begin
            rejected = start;
            if (wait_count_reg != 8'd0) begin
                wait_count_next = wait_count_reg - 8'd1;
            end else begin
                case (phase_reg)
                    PH_ENWAIT: begin
                        if (ce_reg) begin
                            bit_count_next  = '0;
                            io_next         = shift_word_reg[0];
                            phase_next      = PH_SETUP;
                            wait_count_next = BIT_WAIT;
                        end else begin
                            drive_next = 1'b1;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            if (!writing_reg) begin
                                rval = bcd_decode(read_byte_reg, sat_field(active_field_reg));
                            end
                        end
                    end
                    PH_SETUP: begin
                        sclk_next       = 1'b1;
                        phase_next      = PH_HIGH;
                        wait_count_next = BIT_WAIT;
                    end
                    PH_HIGH: begin
                        sclk_next       = 1'b0;
                        phase_next      = PH_LOW;
                        wait_count_next = BIT_WAIT;
                    end
                    PH_LOW: begin
                        bit_count_next = bit_inc;
                        if (bit_inc < bit_limit) begin
                            io_next         = shift_word_reg[bit_inc[3:0]];
                            phase_next      = PH_SETUP;
                            wait_count_next = BIT_WAIT;
                        end else if (!writing_reg) begin
                            io_next         = 1'b0;
                            phase_next      = PH_TURN;
                            wait_count_next = BIT_WAIT;
                        end else begin
                            ce_next         = 1'b0;
                            phase_next      = PH_ENWAIT;
                            wait_count_next = EN_WAIT;
                        end
                    end
                    PH_TURN: begin
                        drive_next      = 1'b0;
                        read_byte_next  = read_byte_reg | 8'(io_in);
                        bit_count_next  = 5'd1;
                        sclk_next       = 1'b1;
                        phase_next      = PH_RHIGH;
                        wait_count_next = BIT_WAIT;
                    end
                    PH_RHIGH: begin
                        sclk_next       = 1'b0;
                        phase_next      = PH_RLOW;
                        wait_count_next = BIT_WAIT;
                    end
                    PH_RLOW: begin
                        if (bit_count_reg < READ_BITS) begin
                            read_byte_next  = read_byte_reg
                                            | (8'(io_in) << bit_count_reg[2:0]);
                            bit_count_next  = bit_inc;
                            sclk_next       = 1'b1;
                            phase_next      = PH_RHIGH;
                            wait_count_next = BIT_WAIT;
                        end else begin
                            ce_next         = 1'b0;
                            phase_next      = PH_ENWAIT;
                            wait_count_next = EN_WAIT;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            wait_count_reg   <= '0;
            shift_word_reg   <= '0;
            read_byte_reg    <= '0;
            active_field_reg <= '0;
            writing_reg      <= 1'b0;
            ce_reg           <= 1'b0;
            sclk_reg         <= 1'b0;
            io_reg           <= 1'b0;
            drive_reg        <= 1'b1;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            wait_count_reg   <= wait_count_next;
            shift_word_reg   <= shift_word_next;
            read_byte_reg    <= read_byte_next;
            active_field_reg <= active_field_next;
            writing_reg      <= writing_next;
            ce_reg           <= ce_next;
            sclk_reg         <= sclk_next;
            io_reg           <= io_next;
            drive_reg        <= drive_next;
        end
    end

    always_comb begin
        result.chip_enable    = ce_next;
        result.serial_clock   = sclk_next;
        result.io_out         = io_next;
        result.io_drive       = drive_next;
        result.busy           = (phase_next != PH_IDLE);
        result.done           = done;
        result.read_value     = rval;
        result.start_rejected = rejected;
    end

endmodule

`default_nettype wire

### rtl/rtc_three_wire_bcd_master.sv
// Three-wire real-time-clock serial master: each request is one microsecond
// tick that carries the sampled data pin and may start a read or a write of
// one calendar field, and each request returns one result with the pin levels
// for that tick, a done strobe and the decoded value of a finished read. A
// request is taken in each cycle that s_ready is high, and its result is
// registered in the result register; a new request is taken in the same cycle
// that the waiting result leaves, and while a result is held back the input stalls.
// After reset the sequencer is idle with all pins low and the data line driven;
// a read takes 4 + 8 * 3 + 1 + 8 * 2 + 4 + 1 ticks and a write
// 4 + 16 * 3 + 4 + 1 ticks at the default wait settings.
// Depends on rtc3w_pkg and rtc3w_seq.
`default_nettype none

module rtc_three_wire_bcd_master
    import rtc3w_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_func,
    input  wire logic [2:0] s_field_index,
    input  wire logic [6:0] s_write_value,
    input  wire logic       s_io_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_chip_enable,
    output logic            m_serial_clock,
    output logic            m_io_out,
    output logic            m_io_drive,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic [6:0]      m_read_value,
    output logic            m_start_rejected
);

    logic    accept;
    logic    m_valid_reg, m_valid_next;
    result_t step_result;
    result_t result_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    rtc3w_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (accept),
        .func        (s_func),
        .field_index (s_field_index),
        .write_value (s_write_value),
        .io_in       (s_io_in),
        .result      (step_result)
    );

    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= step_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_chip_enable    = result_reg.chip_enable;
    assign m_serial_clock   = result_reg.serial_clock;
    assign m_io_out         = result_reg.io_out;
    assign m_io_drive       = result_reg.io_drive;
    assign m_busy_res       = result_reg.busy;
    assign m_done_res       = result_reg.done;
    assign m_read_value     = result_reg.read_value;
    assign m_start_rejected = result_reg.start_rejected;

endmodule

`default_nettype wire

### rtl/rtc3w_checker.sv
// Port-level checker for the three-wire RTC master, bound to the top level.
// Depends on rtc_three_wire_bcd_master_macros.svh.
`default_nettype none
`include "rtc_three_wire_bcd_master_macros.svh"

module rtc3w_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_chip_enable,
    input wire logic       m_io_drive,
    input wire logic       m_busy_res,
    input wire logic       m_done_res,
    input wire logic [6:0] m_read_value
);

    // A finished transaction leaves the block idle with the line driven.
    `RTC3W_ASSERT_IMPL(done_ends_txn, aclk, aresetn, m_valid && m_done_res,
        !m_busy_res && m_io_drive && !m_chip_enable)

    // A decoded value shows only on the done tick.
    `RTC3W_ASSERT_IMPL(value_only_on_done, aclk, aresetn, m_valid && !m_done_res,
        m_read_value == 7'd0)

    // The decoded value never exceeds two decimal digits.
    `RTC3W_ASSERT_IMPL(value_in_range, aclk, aresetn, m_valid, m_read_value <= 7'd99)

    // The data line is released only while a transaction is in progress.
    `RTC3W_ASSERT_IMPL(release_needs_busy, aclk, aresetn, m_valid && !m_io_drive, m_busy_res)

    // A stalled result keeps its value.
    `RTC3W_ASSERT_HOLD(stall_holds_value, aclk, aresetn, m_valid && !m_ready, m_read_value)

endmodule

bind rtc_three_wire_bcd_master rtc3w_checker u_rtc3w_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_chip_enable (m_chip_enable),
    .m_io_drive    (m_io_drive),
    .m_busy_res    (m_busy_res),
    .m_done_res    (m_done_res),
    .m_read_value  (m_read_value)
);

`default_nettype wire
